FILE: rtl/core/scc_pkg.sv
// Package for the strongly connected components block: types and constants.
// No dependencies.
package scc_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR_VIS,
        ST_P1_NEXT,
        ST_P1_START,
        ST_P1_TOP,
        ST_P1_RD,
        ST_P1_CHK,
        ST_P2_INIT,
        ST_P2_NEXT,
        ST_P2_RDF,
        ST_P2_CHKS,
        ST_P2_TOP,
        ST_P2_RD,
        ST_P2_CHK,
        ST_EMIT_SCAN,
        ST_EMIT_OUT,
        ST_CLEAR
    } scc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_all;
        logic clear_visited;
        logic reversed;
        logic load_v_zero;
        logic v_inc;
        logic start_walk;
        logic load_top;
        logic issue_read;
        logic pos_inc;
        logic push_nb;
        logic pop_top;
        logic fin_init;
        logic fin_dec;
        logic fin_read;
        logic clear_members;
        logic emit_set;
        logic emit_done;
        logic comp_inc;
    } scc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic v_end;
        logic v_candidate;
        logic depth_zero;
        logic pos_end;
        logic hit;
        logic fin_zero;
        logic start_visited;
        logic member_any;
        logic out_busy;
    } scc_stat_t;

endpackage

FILE: rtl/core/strongly_connected_components.sv
// Top level of the strongly connected components block (Kosaraju's method).
// Instantiates scc_ctrl and scc_datapath; uses scc_pkg.
//
//  channel  direction  payload                                   handshake
//  s_       in         cmd, from_vertex, to_vertex               s_valid/s_ready
//  m_       out        vertex_id, component_index, last flags,   m_valid/m_ready
//                      edges_dropped
//
// Each edge examined is read, then compared, and a stack top is reloaded
// from the stack memories before its scan resumes; every scan of the vertex
// range steps through the vertices in turn, and each member found is emitted.
// Reset is synchronous; no clearing pass is needed, the counts and mark
// vectors are cleared at once. Emitting a member pauses while the previous
// result waits on m_ready, and no request is taken until the run is finished.
module strongly_connected_components #(
    parameter int VERTS     = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic [5:0] s_from_vertex,
    input  logic [5:0] s_to_vertex,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [5:0] m_vertex_id,
    output logic [5:0] m_component_index,
    output logic       m_last_in_component,
    output logic       m_last_of_run,
    output logic       m_edges_dropped
);
    import scc_pkg::*;

    scc_cmd_t  cmd;
    scc_stat_t stat;
    logic      load_edge;

    scc_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_cmd, .s_ready, .load_edge,
        .stat, .cmd
    );

    scc_datapath #(.VERTS(VERTS), .MAX_EDGES(MAX_EDGES)) u_dp (
        .aclk, .aresetn, .load_edge, .s_from_vertex, .s_to_vertex, .cmd, .stat,
        .m_valid, .m_ready, .m_vertex_id, .m_component_index,
        .m_last_in_component, .m_last_of_run, .m_edges_dropped
    );
endmodule

FILE: rtl/core/scc_datapath.sv
// Datapath for the strongly connected components block: edge, stack and
// finish memories, mark vectors and the output register. Uses scc_pkg.
module scc_datapath #(
    parameter int VERTS     = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load_edge,
    input  logic [5:0]          s_from_vertex,
    input  logic [5:0]          s_to_vertex,
    input  scc_pkg::scc_cmd_t   cmd,
    output scc_pkg::scc_stat_t  stat,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [5:0]          m_vertex_id,
    output logic [5:0]          m_component_index,
    output logic                m_last_in_component,
    output logic                m_last_of_run,
    output logic                m_edges_dropped
);
    import scc_pkg::*;

    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int VW = $clog2(VERTS);
    localparam int DW = $clog2(VERTS + 1);

    logic [5:0]   esrc_mem [MAX_EDGES];
    logic [5:0]   edst_mem [MAX_EDGES];
    logic [5:0]   sv_mem   [VERTS];
    logic [CW-1:0] sp_mem  [VERTS];
    logic [5:0]   fin_mem  [VERTS];

    logic [CW-1:0]    ecount_reg;
    logic             ovf_reg;
    logic [VERTS-1:0] present_reg, visited_reg, member_reg;
    logic [DW-1:0]    depth_reg, fcount_reg, fidx_reg;
    logic [VW:0]      v_reg;
    logic [5:0]       top_v_reg, src_q, dst_q, fin_q;
    logic [CW-1:0]    pos_reg;
    logic [5:0]       comp_reg;
    logic             any_out_reg;
    logic             valid_reg;
    logic [5:0]       ov_reg, oc_reg;
    logic             olc_reg, olr_reg, oed_reg;
    logic [5:0]       pv_reg, pc_reg;
    logic             plc_reg, ped_reg;
    logic             move_out;

    logic [5:0] key, nb, walk_start;
    logic       in_range;

    assign in_range = (32'(s_from_vertex) < VERTS) && (32'(s_to_vertex) < VERTS);
    assign key = cmd.reversed ? dst_q : src_q;
    assign nb  = cmd.reversed ? src_q : dst_q;
    assign walk_start = cmd.reversed ? 6'(v_reg) : fin_q;

    always_ff @(posedge aclk) begin
        if (load_edge && in_range && 32'(ecount_reg) < MAX_EDGES) begin
            esrc_mem[ecount_reg[EW-1:0]] <= s_from_vertex;
            edst_mem[ecount_reg[EW-1:0]] <= s_to_vertex;
        end
        if (cmd.issue_read) begin
            src_q <= esrc_mem[pos_reg[EW-1:0]];
            dst_q <= edst_mem[pos_reg[EW-1:0]];
        end
        if (cmd.fin_read) begin
            fin_q <= fin_mem[fidx_reg[VW-1:0] - 1'b1];
        end
        if (cmd.load_top) begin
            top_v_reg <= sv_mem[depth_reg[VW-1:0] - 1'b1];
            pos_reg   <= sp_mem[depth_reg[VW-1:0] - 1'b1];
        end else if (cmd.pos_inc) begin
            pos_reg <= pos_reg + 1'b1;
        end
        if (cmd.start_walk) begin
            sv_mem[0] <= walk_start;
            sp_mem[0] <= '0;
        end
        if (cmd.push_nb) begin
            // Save the advanced scan position of the current top.
            sp_mem[depth_reg[VW-1:0] - 1'b1] <= pos_reg + 1'b1;
            if (32'(depth_reg) < VERTS) begin
                sv_mem[depth_reg[VW-1:0]] <= nb;
                sp_mem[depth_reg[VW-1:0]] <= '0;
            end
        end
        if (cmd.pop_top && cmd.reversed && 32'(fcount_reg) < VERTS) begin
            fin_mem[fcount_reg[VW-1:0]] <= top_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_all) begin
            ecount_reg  <= '0;
            ovf_reg     <= 1'b0;
            present_reg <= '0;
            visited_reg <= '0;
            member_reg  <= '0;
            depth_reg   <= '0;
            fcount_reg  <= '0;
            comp_reg    <= '0;
            any_out_reg <= 1'b0;
        end else begin
            if (load_edge && in_range) begin
                if (32'(ecount_reg) < MAX_EDGES) begin
                    ecount_reg <= ecount_reg + 1'b1;
                    present_reg[s_from_vertex[VW-1:0]] <= 1'b1;
                    present_reg[s_to_vertex[VW-1:0]]   <= 1'b1;
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.clear_visited) visited_reg <= '0;
            if (cmd.clear_members) member_reg <= '0;
            if (cmd.start_walk) begin
                depth_reg <= DW'(1);
                visited_reg[walk_start[VW-1:0]] <= 1'b1;
                if (!cmd.reversed) member_reg[walk_start[VW-1:0]] <= 1'b1;
            end
            if (cmd.push_nb && 32'(depth_reg) < VERTS) begin
                depth_reg <= depth_reg + 1'b1;
                visited_reg[nb[VW-1:0]] <= 1'b1;
                if (!cmd.reversed) member_reg[nb[VW-1:0]] <= 1'b1;
            end
            if (cmd.pop_top) begin
                depth_reg <= depth_reg - 1'b1;
                if (cmd.reversed && 32'(fcount_reg) < VERTS)
                    fcount_reg <= fcount_reg + 1'b1;
            end
            if (cmd.comp_inc) comp_reg <= comp_reg + 1'b1;
            if (cmd.emit_set) begin
                member_reg[v_reg[VW-1:0]] <= 1'b0;
                any_out_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg    <= '0;
            fidx_reg <= '0;
        end else begin
            if (cmd.load_v_zero) v_reg <= '0;
            else if (cmd.v_inc)  v_reg <= v_reg + 1'b1;
            if (cmd.fin_init)     fidx_reg <= fcount_reg;
            else if (cmd.fin_dec) fidx_reg <= fidx_reg - 1'b1;
        end
    end

    // Output register: a member is held back until the next one (or the end
    // of the run) is known, so that the last flags can be set.
    logic [VERTS-1:0] rest_members;
    always_comb begin
        rest_members = member_reg;
        rest_members[v_reg[VW-1:0]] = 1'b0;
    end

    assign move_out = (cmd.emit_set || cmd.emit_done) && any_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            if (valid_reg && m_ready) valid_reg <= 1'b0;
            if (move_out) valid_reg <= 1'b1;
        end
        if (cmd.emit_set) begin
            pv_reg  <= 6'(v_reg);
            pc_reg  <= comp_reg;
            plc_reg <= (rest_members == '0);
            ped_reg <= ovf_reg;
        end
        if (move_out) begin
            ov_reg  <= pv_reg;
            oc_reg  <= pc_reg;
            olc_reg <= plc_reg;
            olr_reg <= cmd.emit_done;
            oed_reg <= ped_reg;
        end
    end

    assign stat.v_end        = (32'(v_reg) >= VERTS);
    assign stat.v_candidate  = present_reg[v_reg[VW-1:0]] && !visited_reg[v_reg[VW-1:0]];
    assign stat.depth_zero   = (depth_reg == '0);
    assign stat.pos_end      = (pos_reg >= ecount_reg);
    assign stat.hit          = (key == top_v_reg) && !visited_reg[nb[VW-1:0]];
    assign stat.fin_zero     = (fidx_reg == '0);
    assign stat.start_visited = visited_reg[fin_q[VW-1:0]];
    assign stat.member_any   = member_reg[v_reg[VW-1:0]];
    assign stat.out_busy     = valid_reg && !m_ready;

    assign m_valid             = valid_reg;
    assign m_vertex_id         = ov_reg;
    assign m_component_index   = oc_reg;
    assign m_last_in_component = olc_reg;
    assign m_last_of_run       = olr_reg;
    assign m_edges_dropped     = oed_reg;
endmodule

FILE: rtl/core/scc_ctrl.sv
// Controller state machine for the strongly connected components block.
// Uses scc_pkg; drives the command struct of scc_datapath.
module scc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_cmd,
    output logic                s_ready,
    output logic                load_edge,
    input  scc_pkg::scc_stat_t  stat,
    output scc_pkg::scc_cmd_t   cmd
);
    import scc_pkg::*;

    scc_state_t state_reg, state_next;
    logic       rev_reg, rev_next;
    logic       held_reg, held_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rev_reg   <= 1'b1;
            held_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            rev_reg   <= rev_next;
            held_reg  <= held_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        rev_next     = rev_reg;
        held_next    = held_reg;
        cmd          = '0;
        cmd.reversed = rev_reg;
        s_ready      = 1'b0;
        load_edge    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = !stat.out_busy;
                if (s_valid && !stat.out_busy) begin
                    if (!s_cmd) begin
                        load_edge = 1'b1;
                    end else begin
                        rev_next   = 1'b1;
                        held_next  = 1'b0;
                        state_next = ST_CLEAR_VIS;
                    end
                end
            end
            ST_CLEAR_VIS: begin
                cmd.clear_visited = 1'b1;
                cmd.load_v_zero   = 1'b1;
                state_next = ST_P1_NEXT;
            end
            ST_P1_NEXT: begin
                if (stat.v_end) begin
                    rev_next   = 1'b0;
                    state_next = ST_P2_INIT;
                end else if (stat.v_candidate) begin
                    state_next = ST_P1_START;
                end else begin
                    cmd.v_inc = 1'b1;
                end
            end
            ST_P1_START, ST_P2_CHKS: begin
                if (state_reg == ST_P2_CHKS && stat.start_visited) begin
                    state_next = ST_P2_NEXT;
                end else begin
                    cmd.start_walk = 1'b1;
                    if (state_reg == ST_P2_CHKS) cmd.clear_members = 1'b1;
                    state_next = rev_reg ? ST_P1_TOP : ST_P2_TOP;
                end
            end
            ST_P1_TOP, ST_P2_TOP: begin
                if (stat.depth_zero) begin
                    if (rev_reg) begin
                        cmd.v_inc  = 1'b1;
                        state_next = ST_P1_NEXT;
                    end else begin
                        cmd.load_v_zero = 1'b1;
                        state_next = ST_EMIT_SCAN;
                    end
                end else begin
                    cmd.load_top = 1'b1;
                    state_next = rev_reg ? ST_P1_RD : ST_P2_RD;
                end
            end
            ST_P1_RD, ST_P2_RD: begin
                if (stat.pos_end) begin
                    cmd.pop_top = 1'b1;
                    state_next  = rev_reg ? ST_P1_TOP : ST_P2_TOP;
                end else begin
                    cmd.issue_read = 1'b1;
                    state_next = rev_reg ? ST_P1_CHK : ST_P2_CHK;
                end
            end
            ST_P1_CHK, ST_P2_CHK: begin
                if (stat.hit) begin
                    cmd.push_nb = 1'b1;
                    state_next  = rev_reg ? ST_P1_TOP : ST_P2_TOP;
                end else begin
                    cmd.pos_inc = 1'b1;
                    state_next  = rev_reg ? ST_P1_RD : ST_P2_RD;
                end
            end
            ST_P2_INIT: begin
                cmd.clear_visited = 1'b1;
                cmd.fin_init      = 1'b1;
                state_next = ST_P2_NEXT;
            end
            ST_P2_NEXT: begin
                if (stat.fin_zero) begin
                    state_next = ST_CLEAR;
                end else begin
                    cmd.fin_read = 1'b1;
                    cmd.fin_dec  = 1'b1;
                    state_next = ST_P2_RDF;
                end
            end
            ST_P2_RDF: state_next = ST_P2_CHKS;
            ST_EMIT_SCAN: begin
                if (stat.v_end) begin
                    cmd.comp_inc = 1'b1;
                    state_next   = ST_P2_NEXT;
                end else if (stat.member_any) begin
                    state_next = ST_EMIT_OUT;
                end else begin
                    cmd.v_inc = 1'b1;
                end
            end
            ST_EMIT_OUT: begin
                if (!held_reg || !stat.out_busy) begin
                    cmd.emit_set = 1'b1;
                    held_next    = 1'b1;
                    cmd.v_inc    = 1'b1;
                    state_next   = ST_EMIT_SCAN;
                end
            end
            ST_CLEAR: begin
                // The held member can only go out once the output register is free.
                if (!held_reg || !stat.out_busy) begin
                    cmd.emit_done = held_reg;
                    cmd.clear_all = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

FILE: rtl/core/scc_checker.sv
// Port checker for the strongly connected components block, bound to the
// top level. Depends only on the top level's ports.
module scc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [5:0] m_component_index,
    input logic       m_last_in_component,
    input logic       m_last_of_run
);
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped while stalled");
    a_idx_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_component_index))
        else $error("component index changed while stalled");
    a_last_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_of_run |-> m_last_in_component)
        else $error("run ended inside a component");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> !s_ready)
        else $error("request taken during a run");
endmodule

bind strongly_connected_components scc_checker u_scc_checker (
    .aclk, .aresetn, .s_ready, .m_valid, .m_ready,
    .m_component_index, .m_last_in_component, .m_last_of_run
);
